/* src/imu_ts_pkg.sv */
// ----------------------------------------------------------------------------
// imu_ts_pkg
// Shared types, constants and helpers for the IMU sample timestamp tagger.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_ts_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 8;

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
  localparam logic signed [15:0] SAT_LIMIT = 16'sd32760;

  localparam int ERR_OVERRUN = 0;
  localparam int ERR_MISSED  = 1;
  localparam int ERR_ACCEL   = 2;
  localparam int ERR_GYRO    = 3;

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        event_time_us;
    logic [63:0]        current_time_us;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } item_t;

  typedef struct packed {
    logic        sample_valid;
    logic [63:0] sample_time_us;
    logic        accel_saturated;
    logic        gyro_saturated;
    logic        overrun_status;
    logic [3:0]  fault_flags;
    logic [31:0] overrun_total;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  function automatic logic axis_sat(input logic signed [15:0] v);
    axis_sat = (v <= -SAT_LIMIT) || (v >= SAT_LIMIT);
  endfunction

endpackage

`default_nettype wire

/* src/imu_ts_queue.sv */
// ----------------------------------------------------------------------------
// imu_ts_queue
// Bounded timestamp FIFO with a registered read port that always presents
// the oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_ts_queue
  import imu_ts_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_ctrl_t ctrl,
  input  wire logic [31:0] push_data,
  output queue_stat_t      stat,
  output logic [31:0]      front
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [31:0]   mem [QUEUE_DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [CW-1:0] count;
  logic [IW-1:0] tail_next;
  logic [IW-1:0] head_next;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    idx_inc = (i == LAST_IDX) ? '0 : i + IW'(1);
  endfunction

  assign tail_next  = ctrl.pop ? idx_inc(tail) : tail;
  assign head_next  = ctrl.push ? idx_inc(head) : head;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      if (ctrl.push && !ctrl.pop) begin
        count <= count + CW'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[head] <= push_data;
    end
  end

  // read ahead at the next tail, with write-through on a collision
  always_ff @(posedge clk) begin
    if (ctrl.push && (head == tail_next)) begin
      front <= push_data;
    end else begin
      front <= mem[tail_next];
    end
  end

endmodule

`default_nettype wire

/* src/imu_ts_core.sv */
// ----------------------------------------------------------------------------
// imu_ts_core
// Per-transaction tagging logic: queue control, drop folding, clock
// extension, saturation and missed data-ready checks, sticky flags.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_ts_core
  import imu_ts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire item_t       item,
  input  wire logic [31:0] timeout,
  input  wire queue_stat_t qstat,
  input  wire logic [31:0] front,
  output queue_ctrl_t      qctrl,
  output result_t          result
);

  logic [31:0] pending;
  logic [31:0] drop_total;
  logic [3:0]  sticky;
  logic [31:0] clk_high;
  logic [31:0] clk_low_prev;
  logic [63:0] last_time;

  logic [31:0] pending_next;
  logic [31:0] drop_total_next;
  logic [3:0]  sticky_next;
  logic [31:0] clk_high_next;
  logic [31:0] clk_low_prev_next;
  logic [63:0] last_time_next;

  logic [32:0] fold_sum;
  logic [31:0] high_cur;
  logic [63:0] stime;
  logic [64:0] age;
  logic        asat;
  logic        gsat;
  logic        valid;

  assign fold_sum = {1'b0, drop_total} + {1'b0, pending};
  assign high_cur = (item.event_time_us < clk_low_prev) ? clk_high + 32'd1 : clk_high;
  assign age      = {1'b0, item.current_time_us} - {1'b0, last_time};

  always_comb begin
    if (front > item.event_time_us) begin
      if (high_cur == '0) begin
        stime = {32'd0, front};
      end else begin
        stime = {high_cur - 32'd1, front};
      end
    end else begin
      stime = {high_cur, front};
    end
  end

  always_comb begin
    pending_next      = pending;
    drop_total_next   = drop_total;
    sticky_next       = sticky;
    clk_high_next     = clk_high;
    clk_low_prev_next = clk_low_prev;
    last_time_next    = last_time;
    qctrl             = '0;
    valid             = 1'b0;
    asat              = 1'b0;
    gsat              = 1'b0;
    case (mode_t'(item.mode))
      MODE_EVENT: begin
        if (qstat.full) begin
          if (pending != '1) begin
            pending_next = pending + 32'd1;
          end
        end else begin
          qctrl.push = advance;
        end
      end
      MODE_READ: begin
        if (pending != '0) begin
          drop_total_next          = fold_sum[32] ? '1 : fold_sum[31:0];
          sticky_next[ERR_OVERRUN] = 1'b1;
          pending_next             = '0;
        end
        if (!qstat.empty) begin
          qctrl.pop         = advance;
          valid             = 1'b1;
          clk_high_next     = high_cur;
          clk_low_prev_next = item.event_time_us;
          last_time_next    = stime;
          asat = axis_sat(item.accel_x) || axis_sat(item.accel_y) || axis_sat(item.accel_z);
          gsat = axis_sat(item.gyro_x) || axis_sat(item.gyro_y) || axis_sat(item.gyro_z);
          if (asat) begin
            sticky_next[ERR_ACCEL] = 1'b1;
          end
          if (gsat) begin
            sticky_next[ERR_GYRO] = 1'b1;
          end
        end
      end
      MODE_CHECK: begin
        if (!age[64] && (age[63:0] > {32'd0, timeout})) begin
          sticky_next[ERR_MISSED] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.sample_valid    = valid;
    result.sample_time_us  = valid ? stime : '0;
    result.accel_saturated = asat;
    result.gyro_saturated  = gsat;
    result.overrun_status  = (drop_total_next != '0);
    result.fault_flags     = sticky_next;
    result.overrun_total   = drop_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      drop_total   <= '0;
      sticky       <= '0;
      clk_high     <= '0;
      clk_low_prev <= '0;
      last_time    <= '0;
    end else if (advance) begin
      pending      <= pending_next;
      drop_total   <= drop_total_next;
      sticky       <= sticky_next;
      clk_high     <= clk_high_next;
      clk_low_prev <= clk_low_prev_next;
      last_time    <= last_time_next;
    end
  end

endmodule

`default_nettype wire

/* src/imu_sample_timestamp_tagger_top.sv */
// ----------------------------------------------------------------------------
// imu_sample_timestamp_tagger_top
// Timestamp tagger for inertial sensor samples, top level.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. The block
// takes one transaction per clock cycle while out_ready does not stall the
// result: an input register feeds the tagging logic, which updates the queue
// and tracking state and loads the result register once that register is
// free, so a result is presented from the result register after its input
// has passed through the input register. While a result waits on out_ready
// the input register can still take one transaction; after that in_ready
// stays low until the result leaves. The queue read port is registered ahead
// of the pop, so a push followed directly by a read of the same entry still
// sees it. The queue needs no clearing after reset. The timeout register is
// written through cfg_data and should be changed only while the block is idle.
`default_nettype none

module imu_sample_timestamp_tagger_top
  import imu_ts_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [31:0]        event_time_us,
  input  wire logic [63:0]        current_time_us,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] gyro_x,
  input  wire logic signed [15:0] gyro_y,
  input  wire logic signed [15:0] gyro_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    sample_valid,
  output logic [63:0]             sample_time_us,
  output logic                    accel_saturated,
  output logic                    gyro_saturated,
  output logic                    overrun_status,
  output logic [3:0]              fault_flags,
  output logic [31:0]             overrun_total
);

  logic [31:0] timeout;
  logic        item_valid;
  item_t       item;
  logic        advance;
  queue_ctrl_t qctrl;
  queue_stat_t qstat;
  logic [31:0] front;
  result_t     result;
  result_t     result_q;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{mode: mode, event_time_us: event_time_us,
                current_time_us: current_time_us,
                accel_x: accel_x, accel_y: accel_y, accel_z: accel_z,
                gyro_x: gyro_x, gyro_y: gyro_y, gyro_z: gyro_z};
    end
  end

  imu_ts_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (qctrl),
    .push_data(item.event_time_us),
    .stat     (qstat),
    .front    (front)
  );

  imu_ts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .item   (item),
    .timeout(timeout),
    .qstat  (qstat),
    .front  (front),
    .qctrl  (qctrl),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign sample_valid    = result_q.sample_valid;
  assign sample_time_us  = result_q.sample_time_us;
  assign accel_saturated = result_q.accel_saturated;
  assign gyro_saturated  = result_q.gyro_saturated;
  assign overrun_status  = result_q.overrun_status;
  assign fault_flags     = result_q.fault_flags;
  assign overrun_total   = result_q.overrun_total;

endmodule

`default_nettype wire

/* src/imu_ts_checker.sv */
// ----------------------------------------------------------------------------
// imu_ts_checker
// Port-level checks on the result channel of the timestamp tagger.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_ts_checker
  import imu_ts_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        sample_valid,
  input wire logic [63:0] sample_time_us,
  input wire logic        accel_saturated,
  input wire logic        gyro_saturated,
  input wire logic        overrun_status,
  input wire logic [3:0]  fault_flags,
  input wire logic [31:0] overrun_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_time_us)
      && $stable(fault_flags) && $stable(overrun_total))
    else $error("result changed while stalled");

  a_invalid_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |->
      sample_time_us == 64'd0 && !accel_saturated && !gyro_saturated)
    else $error("empty read reported sample data");

  a_overrun_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> overrun_status == (overrun_total != 32'd0)
      && fault_flags[ERR_OVERRUN] == overrun_status)
    else $error("overrun status inconsistent");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!accel_saturated || fault_flags[ERR_ACCEL])
      && (!gyro_saturated || fault_flags[ERR_GYRO]))
    else $error("saturation not recorded in flags");

endmodule

bind imu_sample_timestamp_tagger_top imu_ts_checker u_imu_ts_checker (.*);

`default_nettype wire
